>>> design/lrsgd_pkg.sv
// Shared codes and constants of the logistic regression SGD trainer.
`default_nettype none
package lrsgd_pkg;
   typedef enum logic [1:0] {
      FUNC_FEATURE   = 2'd0,
      FUNC_END_PASS  = 2'd1,
      FUNC_WRITE_W   = 2'd2,
      FUNC_READ_W    = 2'd3
   } func_code_type;

   localparam int unsigned CSR_INDEX_WIDTH = 4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FEATURE_COUNT = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INITIAL_RATE  = 4'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_L2_STRENGTH   = 4'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TRAIN_MODE    = 4'd3;

   localparam logic KIND_PREDICTION = 1'b0;
   localparam logic KIND_READOUT    = 1'b1;

   localparam logic [7:0]  FEATURE_COUNT_RESET = 8'd123;
   localparam logic [15:0] INITIAL_RATE_RESET  = 16'd6554;
   localparam logic [15:0] L2_STRENGTH_RESET   = 16'd655;

   // ceil(2^23 / 10): floor(v / 10) == (v * RECIP_TEN) >> 23 for v < 2^22
   localparam logic [19:0] RECIP_TEN = 20'd838861;
endpackage
`default_nettype wire

>>> design/logistic_regression_sgd_trainer.sv
// Online logistic regression trainer: top level with sequencer and arithmetic.
// Usage:
//  - req_ channel carries one item: a feature (func 0), end of pass (1), weight
//    write (2) or weight read (3). rsp_ channel returns predictions and readouts.
//  - csr_ channel writes feature_count, initial_rate, l2_strength, train_mode.
//  - A feature item passes a weight RAM read, a multiply and an accumulate step.
//    The last feature of a sample adds a sigmoid lookup and result staging,
//    after which its result is registered once the output register is free.
//    In train mode the update then walks the row; a zero feature is read and
//    skipped, a nonzero one is also multiplied and written back, each iteration
//    bound by the registered RAM reads and the chained multipliers.
//  - Weight read: the weight is read and staged, then registered in the output
//    register. Write and end of pass are done when the item is taken.
//  - After reset the weight RAM is cleared entry by entry, during which
//    no item is taken; configuration writes are taken at all times.
//  - Results sit in an output register; a new item is accepted while a
//    result waits there. A later result waits until the receiver takes it.
`default_nettype none
module logistic_regression_sgd_trainer #(
   parameter int unsigned MAX_FEATURES        = 128,
   parameter int unsigned SIGMOID_TABLE_DEPTH = 256
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_valid,
   output      logic                                 csr_ready,
   input  wire logic [lrsgd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [15:0]                          csr_data,
   input  wire logic                                 req_valid,
   output      logic                                 req_ready,
   input  wire logic [1:0]                           req_func,
   input  wire logic signed [15:0]                   req_feature_value,
   input  wire logic                                 req_sample_label,
   input  wire logic [6:0]                           req_weight_index,
   input  wire logic signed [31:0]                   req_weight_value,
   output      logic                                 rsp_valid,
   input  wire logic                                 rsp_ready,
   output      logic                                 rsp_result_kind,
   output      logic [15:0]                          rsp_probability,
   output      logic                                 rsp_predicted_class,
   output      logic                                 rsp_label_match,
   output      logic signed [31:0]                   rsp_weight_readout
);
   import lrsgd_pkg::*;

   localparam int unsigned AW = $clog2(MAX_FEATURES);
   localparam int unsigned CW = $clog2(MAX_FEATURES + 1);
   localparam int unsigned TW = $clog2(SIGMOID_TABLE_DEPTH);

   localparam longint unsigned Q32_ONE     = 64'h1_0000_0000;
   // ceil(2^40 / 3): floor(v / 3) == (v * RECIP_THREE) >> 40 for v < 2^39
   localparam longint unsigned RECIP_THREE = 64'd366503875926;

   typedef logic [15:0] sig_tab_type [SIGMOID_TABLE_DEPTH];

   // restoring division, only evaluated while the table is built
   function automatic longint unsigned udiv64(longint unsigned num,
                                              longint unsigned den);
      longint unsigned q, rem;
      q   = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem  = rem - den;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // exp(-t), t in Q.32, result Q.32
   function automatic longint unsigned exp_neg_q32(longint unsigned t);
      longint unsigned a, t2, t3, t4, r;
      a  = t >> 8;
      t2 = ((a * a) >> 32) >> 1;
      t3 = (((t2 * a) >> 32) * RECIP_THREE) >> 40;
      t4 = ((t3 * a) >> 32) >> 2;
      r  = Q32_ONE - a + t2 - t3 + t4;
      for (int i = 0; i < 8; i++) begin
         r = (r >= Q32_ONE) ? Q32_ONE : ((r * r) >> 32);
      end
      return r;
   endfunction

   function automatic sig_tab_type build_sig_table();
      sig_tab_type     tab;
      longint          x;
      longint unsigned kq, e, d, p;
      for (int k = 0; k < SIGMOID_TABLE_DEPTH; k++) begin
         kq = udiv64(64'(k) << 36, 64'(SIGMOID_TABLE_DEPTH));
         x  = signed'(kq) - (64'sd1 <<< 35);
         if (x >= 0) begin
            e = exp_neg_q32(unsigned'(x));
            d = Q32_ONE + e;
            p = udiv64((64'd1 << 48) + (d >> 1), d);
         end else begin
            e = exp_neg_q32(unsigned'(-x));
            d = Q32_ONE + e;
            p = udiv64((e << 16) + (d >> 1), d);
         end
         tab[k] = (p > 64'd65535) ? 16'hFFFF : p[15:0];
      end
      return tab;
   endfunction

   localparam sig_tab_type SIG_TABLE = build_sig_table();

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_F_MUL, ST_F_ACC, ST_F_SIG, ST_R_RD, ST_OUT,
      ST_U_RD, ST_U_MUL, ST_U_G, ST_U_M3, ST_U_WR
   } state_type;

   state_type state_ff;

   // configuration
   logic [7:0]  feature_count_ff;
   logic [15:0] l2_strength_ff;
   logic        train_mode_ff;
   logic [15:0] rate_ff;

   // sample state
   logic signed [47:0] acc_ff;
   logic [CW-1:0]      cnt_ff;
   logic [AW-1:0]      clr_ff;
   logic signed [15:0] x_ff;
   logic               label_ff;
   logic signed [47:0] prod_ff;
   logic               widx_ok_ff;

   // staged result
   logic        pend_kind_ff;
   logic [15:0] pend_prob_ff;
   logic        pend_cls_ff;
   logic        pend_match_ff;
   logic [31:0] pend_w_ff;
   logic        upd_after_ff;

   // update walk
   logic [CW-1:0]      upd_i_ff;
   logic [CW-1:0]      n_ff;
   logic [15:0]        p_ff;
   logic signed [32:0] m1_ff;
   logic signed [48:0] m2_ff;
   logic signed [33:0] g_ff;
   logic signed [50:0] m3_ff;
   logic signed [31:0] w_ff;

   // output register
   logic        rsp_valid_ff;
   logic        rsp_kind_ff;
   logic [15:0] rsp_prob_ff;
   logic        rsp_cls_ff;
   logic        rsp_match_ff;
   logic [31:0] rsp_w_ff;

   // memories
   logic          w_we, r_we;
   logic [AW-1:0] w_waddr, w_raddr, r_waddr, r_raddr;
   logic [31:0]   w_wdata, w_rdata;
   logic [15:0]   r_wdata, r_rdata;

   lrsgd_ram #(.WIDTH(32), .DEPTH(MAX_FEATURES)) u_weights (
      .clock(clock), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
      .raddr(w_raddr), .rdata(w_rdata)
   );

   lrsgd_ram #(.WIDTH(16), .DEPTH(MAX_FEATURES)) u_row (
      .clock(clock), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
      .raddr(r_raddr), .rdata(r_rdata)
   );

   logic          req_acc, csr_acc, rsp_free;
   logic [AW-1:0] cnt_eff;
   logic [31:0]   widx_wide, fc_wide, n_wide;
   logic          widx_ok;
   logic [CW-1:0] n_use;

   assign req_acc  = req_valid && req_ready;
   assign csr_acc  = csr_valid && csr_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign cnt_eff  = (cnt_ff >= CW'(MAX_FEATURES)) ? '0 : cnt_ff[AW-1:0];

   always_comb begin
      widx_wide = 32'(req_weight_index);
      widx_ok   = widx_wide < MAX_FEATURES;
      fc_wide   = 32'(feature_count_ff);
      if (fc_wide < 1) begin
         n_wide = 32'd1;
      end else if (fc_wide > MAX_FEATURES) begin
         n_wide = MAX_FEATURES;
      end else begin
         n_wide = fc_wide;
      end
      n_use = n_wide[CW-1:0];
   end

   // accumulate with saturation
   logic signed [35:0] prod_sh;
   logic signed [48:0] acc_sum;
   logic signed [47:0] acc_next;
   assign prod_sh = prod_ff[47:12];
   assign acc_sum = {acc_ff[47], acc_ff} + {{13{prod_sh[35]}}, prod_sh};
   always_comb begin
      if (acc_sum[48] != acc_sum[47]) begin
         acc_next = acc_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      end else begin
         acc_next = acc_sum[47:0];
      end
   end

   // sigmoid index
   logic signed [48:0] u_sig;
   logic [63:0]        lin;
   logic [TW-1:0]      sig_idx;
   logic [15:0]        p_look;
   always_comb begin
      u_sig = {acc_ff[47], acc_ff} + 49'sd134217728;
      lin   = {36'd0, u_sig[27:0]} * 64'(SIGMOID_TABLE_DEPTH);
      if (u_sig < 0) begin
         sig_idx = '0;
      end else if (u_sig >= 49'sd268435456) begin
         sig_idx = TW'(SIGMOID_TABLE_DEPTH - 1);
      end else begin
         sig_idx = lin[28 +: TW];
      end
      p_look = SIG_TABLE[sig_idx];
   end

   // update arithmetic
   logic signed [16:0] err;
   logic signed [28:0] m1_sh;
   logic signed [32:0] m2_sh;
   logic signed [34:0] m3_sh;
   logic signed [35:0] w_diff;
   logic signed [31:0] w_new;
   assign err    = label_ff ? $signed({1'b1, p_ff}) : $signed({1'b0, p_ff});
   assign m1_sh  = m1_ff[32:4];
   assign m2_sh  = m2_ff[48:16];
   assign m3_sh  = m3_ff[50:16];
   assign w_diff = {{4{w_ff[31]}}, w_ff} - {m3_sh[34], m3_sh};
   always_comb begin
      if (w_diff > 36'sh0_7FFF_FFFF) begin
         w_new = 32'sh7FFF_FFFF;
      end else if (w_diff < -36'sh0_8000_0000) begin
         w_new = 32'sh8000_0000;
      end else begin
         w_new = w_diff[31:0];
      end
   end

   // end of pass: rate * 9 / 10
   logic [19:0] rate9;
   logic [39:0] rate_q;
   assign rate9  = {1'b0, rate_ff, 3'b000} + 20'(rate_ff);
   assign rate_q = 40'(rate9) * 40'(RECIP_TEN);

   logic [CW-1:0] upd_i_inc;
   assign upd_i_inc = upd_i_ff + 1'b1;

   always_comb begin
      w_we    = 1'b0;
      w_waddr = '0;
      w_wdata = '0;
      w_raddr = upd_i_ff[AW-1:0];
      r_we    = 1'b0;
      r_waddr = cnt_eff;
      r_wdata = req_feature_value;
      r_raddr = upd_i_ff[AW-1:0];
      case (state_ff)
         ST_CLEAR: begin
            w_we    = 1'b1;
            w_waddr = clr_ff;
         end
         ST_IDLE: begin
            if (req_acc) begin
               case (req_func)
                  FUNC_FEATURE: begin
                     w_raddr = cnt_eff;
                     r_we    = 1'b1;
                  end
                  FUNC_WRITE_W: begin
                     w_we    = widx_ok;
                     w_waddr = widx_wide[AW-1:0];
                     w_wdata = req_weight_value;
                  end
                  FUNC_READ_W: w_raddr = widx_wide[AW-1:0];
                  default: ;
               endcase
            end
         end
         ST_U_WR: begin
            w_we    = 1'b1;
            w_waddr = upd_i_ff[AW-1:0];
            w_wdata = w_new;
         end
         default: ;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_CLEAR;
         clr_ff           <= '0;
         feature_count_ff <= FEATURE_COUNT_RESET;
         l2_strength_ff   <= L2_STRENGTH_RESET;
         train_mode_ff    <= 1'b1;
         rate_ff          <= INITIAL_RATE_RESET;
         acc_ff           <= '0;
         cnt_ff           <= '0;
         rsp_valid_ff     <= 1'b0;
         upd_i_ff         <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_acc) begin
            case (csr_index)
               CSR_FEATURE_COUNT: begin
                  feature_count_ff <= csr_data[7:0];
                  acc_ff           <= '0;
                  cnt_ff           <= '0;
               end
               CSR_INITIAL_RATE: rate_ff        <= csr_data;
               CSR_L2_STRENGTH:  l2_strength_ff <= csr_data;
               CSR_TRAIN_MODE:   train_mode_ff  <= csr_data[0];
               default: ;
            endcase
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (32'(clr_ff) == MAX_FEATURES - 1) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_acc) begin
                  case (req_func)
                     FUNC_FEATURE: begin
                        x_ff     <= req_feature_value;
                        label_ff <= req_sample_label;
                        cnt_ff   <= CW'(cnt_eff);
                        state_ff <= ST_F_MUL;
                     end
                     FUNC_END_PASS: begin
                        rate_ff <= rate_q[38:23];
                        acc_ff  <= '0;
                        cnt_ff  <= '0;
                     end
                     FUNC_READ_W: begin
                        widx_ok_ff <= widx_ok;
                        state_ff   <= ST_R_RD;
                     end
                     default: ;
                  endcase
               end
            end
            ST_F_MUL: begin
               prod_ff  <= x_ff * $signed(w_rdata);
               state_ff <= ST_F_ACC;
            end
            ST_F_ACC: begin
               acc_ff <= acc_next;
               cnt_ff <= cnt_ff + 1'b1;
               if ((cnt_ff + 1'b1) < n_use) begin
                  state_ff <= ST_IDLE;
               end else begin
                  n_ff     <= n_use;
                  state_ff <= ST_F_SIG;
               end
            end
            ST_F_SIG: begin
               p_ff          <= p_look;
               pend_kind_ff  <= KIND_PREDICTION;
               pend_prob_ff  <= p_look;
               pend_cls_ff   <= p_look > 16'd32768;
               pend_match_ff <= (p_look > 16'd32768) == label_ff;
               pend_w_ff     <= '0;
               upd_after_ff  <= train_mode_ff;
               acc_ff        <= '0;
               cnt_ff        <= '0;
               state_ff      <= ST_OUT;
            end
            ST_R_RD: begin
               pend_kind_ff  <= KIND_READOUT;
               pend_prob_ff  <= '0;
               pend_cls_ff   <= 1'b0;
               pend_match_ff <= 1'b0;
               pend_w_ff     <= widx_ok_ff ? w_rdata : '0;
               upd_after_ff  <= 1'b0;
               state_ff      <= ST_OUT;
            end
            ST_OUT: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= pend_kind_ff;
                  rsp_prob_ff  <= pend_prob_ff;
                  rsp_cls_ff   <= pend_cls_ff;
                  rsp_match_ff <= pend_match_ff;
                  rsp_w_ff     <= pend_w_ff;
                  upd_i_ff     <= '0;
                  state_ff     <= upd_after_ff ? ST_U_RD : ST_IDLE;
               end
            end
            ST_U_RD: state_ff <= ST_U_MUL;
            ST_U_MUL: begin
               if (r_rdata == '0) begin
                  upd_i_ff <= upd_i_inc;
                  state_ff <= (upd_i_inc == n_ff) ? ST_IDLE : ST_U_RD;
               end else begin
                  m1_ff    <= err * $signed(r_rdata);
                  m2_ff    <= $signed({1'b0, l2_strength_ff}) * $signed(w_rdata);
                  w_ff     <= w_rdata;
                  state_ff <= ST_U_G;
               end
            end
            ST_U_G: begin
               g_ff     <= {{5{m1_sh[28]}}, m1_sh} + {m2_sh[32], m2_sh};
               state_ff <= ST_U_M3;
            end
            ST_U_M3: begin
               m3_ff    <= $signed({1'b0, rate_ff}) * g_ff;
               state_ff <= ST_U_WR;
            end
            ST_U_WR: begin
               upd_i_ff <= upd_i_inc;
               state_ff <= (upd_i_inc == n_ff) ? ST_IDLE : ST_U_RD;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_kind     = rsp_kind_ff;
   assign rsp_probability     = rsp_prob_ff;
   assign rsp_predicted_class = rsp_cls_ff;
   assign rsp_label_match     = rsp_match_ff;
   assign rsp_weight_readout  = rsp_w_ff;

   a_no_item_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_ready)
      else $error("item taken during weight clear");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_FEATURES))
      else $error("feature counter beyond depth");

   a_readout_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind |-> rsp_probability == 16'd0 && !rsp_predicted_class)
      else $error("readout carries prediction fields");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_U_RD |-> upd_i_ff < n_ff)
      else $error("update walk past sample length");
endmodule
`default_nettype wire

>>> design/lrsgd_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
`default_nettype none
module lrsgd_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire
